// ===== src/ths_pkg.sv =====
// Shared types, codes and tournament lookup for the tournament homomorphism search.
package ths_pkg;

  localparam int COLORS = 4;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_TOURNAMENT   = 1'b1;

  localparam logic [1:0] ARC_NONE = 2'b00;
  localparam logic [1:0] ARC_POS  = 2'b01;
  localparam logic [1:0] ARC_NEG  = 2'b11;

  localparam logic [2:0] PAIR_IDX [4][4] = '{
    '{3'd0, 3'd0, 3'd1, 3'd2},
    '{3'd0, 3'd0, 3'd3, 3'd4},
    '{3'd1, 3'd3, 3'd0, 3'd5},
    '{3'd2, 3'd4, 3'd5, 3'd0}
  };

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRY,
    ST_SCAN,
    ST_ASSIGN,
    ST_HUNT,
    ST_JUMP,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_NOTF
  } state_e;

  function automatic logic [1:0] tour_arc(logic [1:0] a, logic [1:0] b, logic [5:0] bits);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [2:0] idx;
    logic       flip;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    idx  = PAIR_IDX[lo][hi];
    flip = bits[idx] ^ (a > b);
    if (a == b) begin
      return ARC_NONE;
    end
    return flip ? ARC_NEG : ARC_POS;
  endfunction

endpackage

// ===== src/ths_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ths_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tournament_homomorphism_search.sv =====
// Top level: arc store loader, backtracking search sequencer and result output.
// Load: one arc word per cycle while idle; a word marked last starts the search.
// Search: a try at depth q reads the arc store once per earlier vertex, an assignment writes
// the color store, and a backjump steps back to the deepest conflicting depth; total is data dependent.
// Output: each result word reads the color store, then is loaded once the consumer is ready.
// Reset clears control state, then a clearing pass zeroes all MAX_VERTICES*MAX_VERTICES
// (256 at default) arc-store entries before the first word is accepted.
module tournament_homomorphism_search #(
  parameter int MAX_VERTICES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        row_i,
  input  logic [3:0]        col_i,
  input  logic signed [1:0] arc_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [3:0]        vertex_o,
  output logic [1:0]        color_o,
  output logic              last_out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [5:0]        cfg_data_i
);
  import ths_pkg::*;

  localparam int LIM   = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
  localparam int QW    = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int NW    = $clog2(LIM + 1);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_e state_q, state_d;

  logic [4:0]     vcount_q, vcount_d;
  logic [5:0]     tbits_q, tbits_d;
  logic [NW-1:0]  n_q, n_d;
  logic [QW-1:0]  q_q, q_d;
  logic [QW-1:0]  p_q, p_d;
  logic [QW-1:0]  chk_p_q, chk_p_d;
  logic           chk_v_q, chk_v_d;
  logic [LIM-1:0] mask_q, mask_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [2:0]     tries_q [LIM];
  logic [2:0]     tries_d [LIM];
  logic [LIM-1:0] conf_q [LIM];
  logic [LIM-1:0] conf_d [LIM];

  logic           out_valid_q, out_valid_d;
  logic           found_q, found_d;
  logic [3:0]     vertex_q, vertex_d;
  logic [1:0]     color_q, color_d;
  logic           last_q, last_d;

  logic           arc_we, arc_re;
  logic [AW-1:0]  arc_waddr, arc_raddr;
  logic [1:0]     arc_wdata, arc_rdata;
  logic           col_we, col_re;
  logic [QW-1:0]  col_raddr;
  logic [1:0]     col_rdata;

  logic           in_range;
  logic           out_free;
  logic           conflict;
  logic [NW-1:0]  last_idx;

  ths_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_arc_ram (
    .clk_i   (clk_i),
    .we_i    (arc_we),
    .waddr_i (arc_waddr),
    .wdata_i (arc_wdata),
    .re_i    (arc_re),
    .raddr_i (arc_raddr),
    .rdata_o (arc_rdata)
  );

  ths_ram #(.WIDTH(2), .DEPTH(LIM)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (q_q),
    .wdata_i (tries_q[q_q][1:0]),
    .re_i    (col_re),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  assign in_range = (32'(row_i) < MAX_VERTICES) && (32'(col_i) < MAX_VERTICES);
  assign out_free = !out_valid_q || out_ready_i;
  assign last_idx = NW'(n_q - NW'(1));
  assign conflict = (arc_rdata != ARC_NONE) &&
                    (tour_arc(col_rdata, tries_q[q_q][1:0], tbits_q) != arc_rdata);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign vertex_o    = vertex_q;
  assign color_o     = color_q;
  assign last_out_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      vcount_q    <= 5'd16;
      tbits_q     <= 6'd17;
      clr_q       <= '0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      tbits_q     <= tbits_d;
      clr_q       <= clr_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    q_q      <= q_d;
    p_q      <= p_d;
    chk_p_q  <= chk_p_d;
    mask_q   <= mask_d;
    tries_q  <= tries_d;
    conf_q   <= conf_d;
    found_q  <= found_d;
    vertex_q <= vertex_d;
    color_q  <= color_d;
    last_q   <= last_d;
  end

  always_comb begin
    state_d     = state_q;
    vcount_d    = vcount_q;
    tbits_d     = tbits_q;
    n_d         = n_q;
    q_d         = q_q;
    p_d         = p_q;
    chk_p_d     = chk_p_q;
    chk_v_d     = 1'b0;
    mask_d      = mask_q;
    clr_d       = clr_q;
    tries_d     = tries_q;
    conf_d      = conf_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    found_d     = found_q;
    vertex_d    = vertex_q;
    color_d     = color_q;
    last_d      = last_q;
    arc_we      = 1'b0;
    arc_waddr   = AW'(int'(row_i) * MAX_VERTICES + int'(col_i));
    arc_wdata   = arc_i;
    arc_re      = 1'b0;
    arc_raddr   = AW'(int'(p_q) * MAX_VERTICES + int'(q_q));
    col_we      = 1'b0;
    col_re      = 1'b0;
    col_raddr   = p_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_VERTEX_COUNT: vcount_d = cfg_data_i[4:0];
        CFG_TOURNAMENT:   tbits_d  = cfg_data_i;
        default:          vcount_d = vcount_q;
      endcase
    end

    unique case (state_q)
      ST_CLEAR: begin
        arc_we    = 1'b1;
        arc_waddr = clr_q;
        arc_wdata = ARC_NONE;
        clr_d     = AW'(clr_q + AW'(1));
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          arc_we = in_range;
          if (last_i) begin
            if (vcount_q == 5'd0) begin
              n_d = NW'(1);
            end else if (vcount_q > 5'(LIM)) begin
              n_d = NW'(LIM);
            end else begin
              n_d = NW'(vcount_q);
            end
            q_d        = '0;
            tries_d[0] = '0;
            conf_d[0]  = '0;
            state_d    = ST_TRY;
          end
        end
      end
      ST_TRY: begin
        if (!tries_q[q_q][2]) begin
          p_d = '0;
          state_d = (q_q == '0) ? ST_ASSIGN : ST_SCAN;
        end else if (conf_q[q_q] == '0) begin
          state_d = ST_NOTF;
        end else begin
          mask_d  = conf_q[q_q];
          state_d = ST_HUNT;
        end
      end
      ST_SCAN: begin
        if (p_q < q_q) begin
          arc_re  = 1'b1;
          col_re  = 1'b1;
          chk_v_d = 1'b1;
          chk_p_d = p_q;
          p_d     = QW'(p_q + QW'(1));
        end
        if (chk_v_q) begin
          if (conflict) begin
            conf_d[q_q][chk_p_q] = 1'b1;
            tries_d[q_q]         = 3'(tries_q[q_q] + 3'd1);
            chk_v_d              = 1'b0;
            state_d              = ST_TRY;
          end else if (chk_p_q == QW'(q_q - QW'(1))) begin
            chk_v_d = 1'b0;
            state_d = ST_ASSIGN;
          end
        end
      end
      ST_ASSIGN: begin
        col_we = 1'b1;
        if (NW'(q_q) == last_idx) begin
          p_d     = '0;
          state_d = ST_OUT_RD;
        end else begin
          q_d                                = QW'(q_q + QW'(1));
          tries_d[QW'(q_q + QW'(1))]         = '0;
          conf_d[QW'(q_q + QW'(1))]          = '0;
          state_d                            = ST_TRY;
        end
      end
      ST_HUNT: begin
        q_d = QW'(q_q - QW'(1));
        if (mask_q[QW'(q_q - QW'(1))]) begin
          state_d = ST_JUMP;
        end
      end
      ST_JUMP: begin
        conf_d[q_q]  = conf_q[q_q] | (mask_q & ~(LIM'(1) << q_q));
        tries_d[q_q] = 3'(tries_q[q_q] + 3'd1);
        state_d      = ST_TRY;
      end
      ST_OUT_RD: begin
        col_re  = 1'b1;
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          vertex_d    = 4'(p_q);
          color_d     = col_rdata;
          last_d      = (NW'(p_q) == last_idx);
          if (NW'(p_q) == last_idx) begin
            state_d = ST_IDLE;
          end else begin
            p_d     = QW'(p_q + QW'(1));
            state_d = ST_OUT_RD;
          end
        end
      end
      ST_NOTF: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          vertex_d    = '0;
          color_d     = '0;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (p_q <= q_q))
    else $error("scan index ran past current depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HUNT) |-> (mask_q != '0))
    else $error("backjump with empty conflict set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ASSIGN) |-> (NW'(q_q) < n_q))
    else $error("assignment beyond vertex count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> last_out_o)
    else $error("not-found word without last mark");

endmodule

// ===== verif/ths_checker.sv =====
// Checker for the tournament homomorphism search: predicts colorings and compares result words.
module ths_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [3:0]        row_i,
  input  logic [3:0]        col_i,
  input  logic signed [1:0] arc_i,
  input  logic              last_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              found_i,
  input  logic [3:0]        vertex_i,
  input  logic [1:0]        color_i,
  input  logic              last_out_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [5:0]        cfg_data_i,
  output int                mismatches_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ths_pkg::*;

  typedef struct packed {
    logic       found;
    logic [3:0] vertex;
    logic [1:0] color;
    logic       last;
  } color_word_t;

  int          arcs [16][16];
  logic [4:0]  vcount;
  logic [5:0]  tbits;
  logic [1:0]  coloring [16];
  color_word_t due_words [$];
  color_word_t want;
  color_word_t next_word;
  int          errs;
  int          nverts;

  function automatic int tour_value(logic [1:0] a, logic [1:0] b);
    int lo;
    int hi;
    int idx;
    int v;
    if (a == b) return 0;
    lo  = (a < b) ? int'(a) : int'(b);
    hi  = (a < b) ? int'(b) : int'(a);
    idx = (lo == 0) ? hi - 1 : (lo == 1) ? hi + 1 : 5;
    v   = tbits[idx] ? -1 : 1;
    return (a < b) ? v : -v;
  endfunction

  function automatic int first_clash(int q, logic [1:0] c);
    for (int p = 0; p < q; p++) begin
      if (arcs[p][q] != 0 && tour_value(coloring[p], c) != arcs[p][q]) return p;
    end
    return -1;
  endfunction

  // Depth-first search with conflict-directed backjumping; leaves the result in coloring.
  function automatic bit find_coloring(int n);
    int          depth;
    int          hit;
    int          back;
    int          tried [16];
    logic [15:0] blame [16];
    bit          done;
    bit          ok;
    depth    = 0;
    tried[0] = 0;
    blame[0] = '0;
    done     = 1'b0;
    ok       = 1'b0;
    while (!done) begin
      if (tried[depth] < COLORS) begin
        hit = first_clash(depth, 2'(tried[depth]));
        if (hit < 0) begin
          coloring[depth] = 2'(tried[depth]);
          if (depth + 1 >= n) begin
            done = 1'b1;
            ok   = 1'b1;
          end else begin
            depth++;
            tried[depth] = 0;
            blame[depth] = '0;
          end
        end else begin
          blame[depth][hit] = 1'b1;
          tried[depth]++;
        end
      end else if (blame[depth] == '0) begin
        done = 1'b1;
      end else begin
        back = 0;
        for (int i = 0; i < 16; i++) begin
          if (blame[depth][i]) back = i;
        end
        blame[back] |= blame[depth] & ~(16'd1 << back);
        depth = back;
        tried[depth]++;
      end
    end
    return ok;
  endfunction

  function automatic void check_field(string what, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $display("%0t ths_checker: %s expected %0d got %0d", $time, what, exp_val, got_val);
      errs++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 16; r++) begin
        for (int c = 0; c < 16; c++) arcs[r][c] = 0;
      end
      vcount = 5'd16;
      tbits  = 6'd17;
      due_words.delete();
      errs = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_VERTEX_COUNT) begin
          vcount = cfg_data_i[4:0];
        end else begin
          tbits = cfg_data_i;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (due_words.size() == 0) begin
          $display("%0t ths_checker: unexpected word expected none %s %0d %0d %0d %0d",
                   $time, "got found/vertex/color/last", found_i, vertex_i, color_i,
                   last_out_i);
          errs++;
        end else begin
          want = due_words.pop_front();
          check_field("found", want.found, found_i);
          check_field("vertex", want.vertex, vertex_i);
          check_field("color", want.color, color_i);
          check_field("last_out", want.last, last_out_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        arcs[row_i][col_i] = arc_i;
        if (last_i) begin
          nverts = (vcount == 5'd0) ? 1 : (vcount > 5'd16) ? 16 : int'(vcount);
          if (find_coloring(nverts)) begin
            for (int v = 0; v < nverts; v++) begin
              next_word = '{1'b1, 4'(v), coloring[v], 1'(v == nverts - 1)};
              due_words.insert(due_words.size(), next_word);
            end
          end else begin
            next_word = '{1'b0, 4'd0, 2'd0, 1'b1};
            due_words.insert(due_words.size(), next_word);
          end
        end
      end
      mismatches_o <= errs;
      pending_o    <= due_words.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the tournament homomorphism search: stimulus, idling phases and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ths_pkg::*;

  localparam int         LIMIT   = 1_000_000;
  localparam int         SETTLE  = 20;
  localparam logic [1:0] ARC_BAD = 2'b10;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [3:0]        row_i = '0;
  logic [3:0]        col_i = '0;
  logic signed [1:0] arc_i = '0;
  logic              last_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              found_o;
  logic [3:0]        vertex_o;
  logic [1:0]        color_o;
  logic              last_out_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = 1'b0;
  logic [5:0]        cfg_data_i = '0;

  int mismatches;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tournament_homomorphism_search u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .row_i, .col_i, .arc_i, .last_i,
    .out_valid_o, .out_ready_i, .found_o, .vertex_o, .color_o, .last_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  ths_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .row_i, .col_i, .arc_i, .last_i,
    .out_valid_i(out_valid_o), .out_ready_i, .found_i(found_o), .vertex_i(vertex_o),
    .color_i(color_o), .last_out_i(last_out_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send_word(input logic [3:0] r, input logic [3:0] c, input logic [1:0] a,
                           input logic l);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_i      <= r;
    col_i      <= c;
    arc_i      <= a;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic idx, input logic [5:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, drain every expected word, then give the block time to go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Rewrite every checked pair with arcs that fit a random coloring.
  task automatic load_planted(input int n, input logic [5:0] tb);
    logic [1:0] pick [16];
    logic [1:0] a;
    if (n == 1) begin
      send_word(4'($urandom), 4'($urandom), 2'($urandom), 1'b1);
    end else begin
      for (int v = 0; v < n; v++) pick[v] = 2'($urandom_range(3, 0));
      for (int p = 0; p < n - 1; p++) begin
        for (int q = p + 1; q < n; q++) begin
          a = ($urandom_range(3, 0) == 0) ? ARC_NONE : tour_arc(pick[p], pick[q], tb);
          send_word(4'(p), 4'(q), a, (p == n - 2) && (q == n - 1));
        end
      end
    end
  endtask

  task automatic load_noise();
    int k;
    k = $urandom_range(6, 1);
    for (int i = 0; i < k; i++) begin
      send_word(4'($urandom), 4'($urandom), 2'($urandom), i == k - 1);
    end
  endtask

  task automatic run_phase(input logic [5:0] vc, input logic [5:0] tb, input int idle,
                           input int stall, input int seqs);
    int n;
    write_reg(CFG_VERTEX_COUNT, vc);
    write_reg(CFG_TOURNAMENT, tb);
    idle_pct  = idle;
    stall_pct = stall;
    n = (vc[4:0] == 5'd0) ? 1 : (vc[4:0] > 5'd16) ? 16 : int'(vc[4:0]);
    repeat (seqs) begin
      if ($urandom_range(3, 0) == 0) begin
        load_noise();
      end else begin
        load_planted(n, tb);
      end
    end
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_VERTEX_COUNT, 6'd4);
    write_reg(CFG_TOURNAMENT, 6'd17);
    send_word(4'd0, 4'd0, ARC_NONE, 1'b1);
    send_word(4'd0, 4'd1, ARC_BAD, 1'b0);
    send_word(4'd0, 4'd2, ARC_POS, 1'b1);
    send_word(4'd0, 4'd1, ARC_NONE, 1'b0);
    send_word(4'd2, 4'd1, ARC_BAD, 1'b0);
    send_word(4'd5, 4'd6, ARC_BAD, 1'b0);
    send_word(4'd15, 4'd15, ARC_BAD, 1'b0);
    send_word(4'd15, 4'd0, ARC_POS, 1'b0);
    send_word(4'd0, 4'd15, ARC_NEG, 1'b0);
    send_word(4'd1, 4'd3, ARC_NEG, 1'b1);
    send_word(4'd0, 4'd3, ARC_POS, 1'b0);
    send_word(4'd1, 4'd2, ARC_POS, 1'b0);
    send_word(4'd2, 4'd3, ARC_NEG, 1'b1);
    settle();

    run_phase(6'd3, 6'd0, 0, 0, 8);
    run_phase(6'd5, 6'd63, 66, 0, 5);
    run_phase(6'd0, 6'($urandom), 0, 66, 15);
    run_phase(6'd6, 6'($urandom), 18, 18, 4);
    run_phase(6'd40, 6'($urandom), 66, 66, 2);
    run_phase(6'd31, 6'($urandom), 0, 0, 1);
    run_phase(6'd1, 6'($urandom), 66, 0, 3);
    run_phase(6'd2, 6'($urandom), 18, 18, 10);

    if (mismatches == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
